FILE: src/bcf_pkg.sv
// ----------------------------------------------------------------------------
// bcf_pkg
// Types, microcode word layout and constants shared by the curve flattener.
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int COORD_W = 32;
    localparam int SEG_W   = 6;
    localparam int COLOR_W = 32;
    localparam int T_FRAC  = 16;
    localparam int T_W     = T_FRAC + 1;
    localparam int TERM_W  = T_W + COORD_W + 1 - T_FRAC;
    localparam int ACC_W   = TERM_W + 2;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic               mode;
        coord_t             start_x;
        coord_t             start_y;
        coord_t             ctrl1_x;
        coord_t             ctrl1_y;
        coord_t             ctrl2_x;
        coord_t             ctrl2_y;
        coord_t             end_x;
        coord_t             end_y;
        logic [SEG_W-1:0]   segments;
        logic [COLOR_W-1:0] color;
    } req_beat_t;

    typedef struct packed {
        coord_t             vert_x;
        coord_t             vert_y;
        logic [COLOR_W-1:0] vert_color;
        logic               last;
    } vtx_beat_t;

    // floor(65536 / n) for n = 1 .. 32, entry 0 unused
    localparam logic [T_W-1:0] STEP_LUT [0:32] = '{
        17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107,
        17'd10922, 17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,
        17'd5461,  17'd5041,  17'd4681,  17'd4369,  17'd4096,  17'd3855,
        17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
        17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,
        17'd2184,  17'd2114,  17'd2048
    };

    typedef enum logic [1:0] {OPD_U, OPD_T, OPD_U2, OPD_T2} opd_t;
    typedef enum logic [1:0] {SC_ZERO, SC_ONE, SC_TWO, SC_THREE} scale_t;
    typedef enum logic [2:0] {WD_U2, WD_T2, WD_W0, WD_W1, WD_W2, WD_W3} wdst_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_t;
    typedef enum logic [2:0] {CND_NONE, CND_ALWAYS, CND_CUBIC, CND_FIRST, CND_MORE} cond_t;
    typedef enum logic {VS_CUR, VS_END} vsrc_t;

    typedef enum logic [4:0] {
        ST_BRANCH,
        ST_Q_B0, ST_Q_B1, ST_Q_B2, ST_Q_ZERO,
        ST_C_U2, ST_C_T2, ST_C_B0, ST_C_B1, ST_C_B2, ST_C_B3,
        ST_X0, ST_X1, ST_X2, ST_X3,
        ST_Y0, ST_Y1, ST_Y2, ST_Y3,
        ST_Y_ADD, ST_Y_STORE,
        ST_EMIT_A, ST_EMIT_B, ST_ADVANCE, ST_FINAL
    } step_t;

    typedef struct packed {
        logic      wmul_en;
        opd_t      opd_a;
        opd_t      opd_b;
        scale_t    scale;
        wdst_t     wdst;
        logic      cmul_en;
        logic [1:0] term;
        logic      axis_y;
        acc_t      acc;
        logic      store_x;
        logic      store_y;
    } dp_ctrl_t;

    typedef struct packed {
        dp_ctrl_t  dp;
        logic      emit;
        vsrc_t     emit_src;
        logic      emit_last;
        logic      advance;
        logic      done;
        cond_t     cond;
        step_t     target;
    } ctrl_t;

    localparam dp_ctrl_t DP_IDLE = '0;
    localparam ctrl_t    CW_NOP  = '0;

endpackage

FILE: src/bcf_datapath.sv
// ----------------------------------------------------------------------------
// bcf_datapath
// Bernstein weight unit, weighted coordinate multiplier, accumulator and
// saturation, all driven one step at a time by the microcode word.
// ----------------------------------------------------------------------------
module bcf_datapath
    import bcf_pkg::*;
(
    input  logic           clk,
    input  dp_ctrl_t       ctrl,
    input  logic [T_W-1:0] t,
    input  coord_t         px [4],
    input  coord_t         py [4],
    output coord_t         cur_x,
    output coord_t         cur_y
);

    logic [T_W-1:0]           u;
    logic [T_W-1:0]           u2_reg;
    logic [T_W-1:0]           t2_reg;
    logic [T_W-1:0]           w_reg [4];
    logic [T_W-1:0]           opa;
    logic [T_W-1:0]           opb;
    logic [2*T_W-1:0]         wprod;
    logic [2*T_W+1:0]         wscaled;
    logic [T_W-1:0]           wnew;
    logic [T_W-1:0]           w_sel;
    coord_t                   p_sel;
    logic signed [T_W+COORD_W:0] cprod;
    logic signed [TERM_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    coord_t                   cur_x_reg;
    coord_t                   cur_y_reg;

    function automatic coord_t sat_coord(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:COORD_W-1]) || !(|v[ACC_W-1:COORD_W-1]);
        if (fits)
            return coord_t'(v[COORD_W-1:0]);
        else if (v[ACC_W-1])
            return coord_t'({1'b1, {(COORD_W-1){1'b0}}});
        else
            return coord_t'({1'b0, {(COORD_W-1){1'b1}}});
    endfunction

    assign u = T_ONE - t;

    always_comb
    begin
        unique case (ctrl.opd_a)
            OPD_U:   opa = u;
            OPD_T:   opa = t;
            OPD_U2:  opa = u2_reg;
            OPD_T2:  opa = t2_reg;
            default: opa = t;
        endcase
        unique case (ctrl.opd_b)
            OPD_U:   opb = u;
            OPD_T:   opb = t;
            OPD_U2:  opb = u2_reg;
            OPD_T2:  opb = t2_reg;
            default: opb = t;
        endcase
    end

    assign wprod = opa * opb;

    always_comb
    begin
        unique case (ctrl.scale)
            SC_ZERO:  wscaled = '0;
            SC_ONE:   wscaled = {2'b00, wprod};
            SC_TWO:   wscaled = {1'b0, wprod, 1'b0};
            SC_THREE: wscaled = {2'b00, wprod} + {1'b0, wprod, 1'b0};
            default:  wscaled = '0;
        endcase
    end

    // Every weight stays at or below 1.0, so 17 bits after the shift hold it
    assign wnew  = wscaled[T_FRAC +: T_W];

    assign w_sel = w_reg[ctrl.term];
    assign p_sel = ctrl.axis_y ? py[ctrl.term] : px[ctrl.term];
    assign cprod = $signed({1'b0, w_sel}) * p_sel;

    always_ff @(posedge clk)
    begin
        if (ctrl.wmul_en)
        begin
            unique case (ctrl.wdst)
                WD_U2:   u2_reg   <= wnew;
                WD_T2:   t2_reg   <= wnew;
                WD_W0:   w_reg[0] <= wnew;
                WD_W1:   w_reg[1] <= wnew;
                WD_W2:   w_reg[2] <= wnew;
                WD_W3:   w_reg[3] <= wnew;
                default: ;
            endcase
        end

        // Arithmetic shift of the product gives the floor of each term
        if (ctrl.cmul_en)
            prod_reg <= cprod[T_W+COORD_W:T_FRAC];

        unique case (ctrl.acc)
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            default:  ;
        endcase

        if (ctrl.store_x)
            cur_x_reg <= sat_coord(acc_reg);
        if (ctrl.store_y)
            cur_y_reg <= sat_coord(acc_reg);
    end

    assign cur_x = cur_x_reg;
    assign cur_y = cur_y_reg;

endmodule

FILE: src/bezier_curve_flattener.sv
// ----------------------------------------------------------------------------
// bezier_curve_flattener
// Takes one quadratic or cubic curve per request beat and returns it as a
// line list of 2*segments vertex beats, the final one marked last. Each
// curve point is worked out by a microcoded sequencer over one weight
// multiplier and one coordinate multiplier. A segment count of 0 reads as
// 1, anything above MAX_SEGMENTS as MAX_SEGMENTS. The next request is
// taken once the final vertex sits in the output register. Coordinates
// are signed Q16.16, colour is copied unchanged.
// ----------------------------------------------------------------------------
module bezier_curve_flattener
    import bcf_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_beat_t req,
    output logic      vtx_valid,
    input  logic      vtx_ready,
    output vtx_beat_t vtx
);

    localparam int N_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);

    logic             busy_reg;
    logic             busy_next;
    step_t            pc_reg;
    step_t            pc_next;
    logic [N_W-1:0]   i_reg;
    logic [N_W-1:0]   i_next;
    logic [T_W-1:0]   t_reg;
    logic [T_W-1:0]   t_next;
    logic [N_W-1:0]   n_reg;
    logic [T_W-1:0]   step_reg;
    req_beat_t        req_reg;
    logic             vtx_valid_reg;
    logic             vtx_valid_next;
    vtx_beat_t        vtx_beat_reg;
    vtx_beat_t        vtx_beat_next;

    ctrl_t            cw;
    dp_ctrl_t         dp_ctrl;
    logic             accept;
    logic             slot_free;
    logic             go;
    logic             jump;
    logic [SEG_W-1:0] n_clamp;
    coord_t           px [4];
    coord_t           py [4];
    coord_t           cur_x;
    coord_t           cur_y;

    // ---- microprogram -----------------------------------------------------

    function automatic ctrl_t f_wmul(input opd_t a, input opd_t b, input scale_t sc,
                                     input wdst_t dst);
        ctrl_t c;
        c            = CW_NOP;
        c.dp.wmul_en = 1'b1;
        c.dp.opd_a   = a;
        c.dp.opd_b   = b;
        c.dp.scale   = sc;
        c.dp.wdst    = dst;
        return c;
    endfunction

    function automatic ctrl_t f_dp(input logic mul, input logic [1:0] term,
                                   input logic axis_y, input acc_t acc,
                                   input logic st_x, input logic st_y);
        ctrl_t c;
        c            = CW_NOP;
        c.dp.cmul_en = mul;
        c.dp.term    = term;
        c.dp.axis_y  = axis_y;
        c.dp.acc     = acc;
        c.dp.store_x = st_x;
        c.dp.store_y = st_y;
        return c;
    endfunction

    function automatic ctrl_t f_emit(input vsrc_t src, input logic fin);
        ctrl_t c;
        c           = CW_NOP;
        c.emit      = 1'b1;
        c.emit_src  = src;
        c.emit_last = fin;
        c.done      = fin;
        return c;
    endfunction

    function automatic ctrl_t f_jump(input ctrl_t base, input cond_t cnd, input step_t tgt);
        ctrl_t c;
        c        = base;
        c.cond   = cnd;
        c.target = tgt;
        return c;
    endfunction

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        c         = CW_NOP;
        c.advance = 1'b1;
        unique case (s)
            ST_BRANCH:  return f_jump(CW_NOP, CND_CUBIC, ST_C_U2);
            // quadratic: the end point weight lands in W3, W2 is cleared
            ST_Q_B0:    return f_wmul(OPD_U, OPD_U, SC_ONE, WD_W0);
            ST_Q_B1:    return f_wmul(OPD_U, OPD_T, SC_TWO, WD_W1);
            ST_Q_B2:    return f_wmul(OPD_T, OPD_T, SC_ONE, WD_W3);
            ST_Q_ZERO:  return f_jump(f_wmul(OPD_U, OPD_U, SC_ZERO, WD_W2), CND_ALWAYS,
                                      ST_X0);
            ST_C_U2:    return f_wmul(OPD_U, OPD_U, SC_ONE, WD_U2);
            ST_C_T2:    return f_wmul(OPD_T, OPD_T, SC_ONE, WD_T2);
            ST_C_B0:    return f_wmul(OPD_U2, OPD_U, SC_ONE, WD_W0);
            ST_C_B1:    return f_wmul(OPD_U2, OPD_T, SC_THREE, WD_W1);
            ST_C_B2:    return f_wmul(OPD_U, OPD_T2, SC_THREE, WD_W2);
            ST_C_B3:    return f_wmul(OPD_T2, OPD_T, SC_ONE, WD_W3);
            // accumulate trails the multiplier by one step
            ST_X0:      return f_dp(1'b1, 2'd0, 1'b0, ACC_HOLD, 1'b0, 1'b0);
            ST_X1:      return f_dp(1'b1, 2'd1, 1'b0, ACC_LOAD, 1'b0, 1'b0);
            ST_X2:      return f_dp(1'b1, 2'd2, 1'b0, ACC_ADD,  1'b0, 1'b0);
            ST_X3:      return f_dp(1'b1, 2'd3, 1'b0, ACC_ADD,  1'b0, 1'b0);
            ST_Y0:      return f_dp(1'b1, 2'd0, 1'b1, ACC_ADD,  1'b0, 1'b0);
            ST_Y1:      return f_dp(1'b1, 2'd1, 1'b1, ACC_LOAD, 1'b1, 1'b0);
            ST_Y2:      return f_dp(1'b1, 2'd2, 1'b1, ACC_ADD,  1'b0, 1'b0);
            ST_Y3:      return f_dp(1'b1, 2'd3, 1'b1, ACC_ADD,  1'b0, 1'b0);
            ST_Y_ADD:   return f_dp(1'b0, 2'd0, 1'b1, ACC_ADD,  1'b0, 1'b0);
            ST_Y_STORE: return f_dp(1'b0, 2'd0, 1'b1, ACC_HOLD, 1'b0, 1'b1);
            // inner points close one segment and open the next
            ST_EMIT_A:  return f_jump(f_emit(VS_CUR, 1'b0), CND_FIRST, ST_ADVANCE);
            ST_EMIT_B:  return f_emit(VS_CUR, 1'b0);
            ST_ADVANCE: return f_jump(c, CND_MORE, ST_BRANCH);
            ST_FINAL:   return f_jump(f_emit(VS_END, 1'b1), CND_ALWAYS, ST_BRANCH);
            default:    return f_jump(CW_NOP, CND_ALWAYS, ST_BRANCH);
        endcase
    endfunction

    // ---- sequencer --------------------------------------------------------

    assign cw        = ucode(pc_reg);
    assign req_ready = !busy_reg;
    assign accept    = req_valid && req_ready;
    assign slot_free = !vtx_valid_reg || vtx_ready;
    assign go        = busy_reg && (!cw.emit || slot_free);
    assign dp_ctrl   = go ? cw.dp : DP_IDLE;

    always_comb
    begin
        priority if (req.segments == '0)
            n_clamp = SEG_W'(1);
        else if (req.segments > SEG_MAX)
            n_clamp = SEG_MAX;
        else
            n_clamp = req.segments;
    end

    always_comb
    begin
        unique case (cw.cond)
            CND_NONE:   jump = 1'b0;
            CND_ALWAYS: jump = 1'b1;
            CND_CUBIC:  jump = req_reg.mode;
            CND_FIRST:  jump = (i_reg == '0);
            CND_MORE:   jump = (i_reg != N_W'(n_reg - 1'b1));
            default:    jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        i_next         = i_reg;
        t_next         = t_reg;
        vtx_valid_next = vtx_valid_reg && !vtx_ready;
        vtx_beat_next  = vtx_beat_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = ST_BRANCH;
            i_next    = '0;
            t_next    = '0;
        end
        else if (go)
        begin
            pc_next = jump ? cw.target : step_t'(pc_reg + 1'b1);
            if (cw.advance)
            begin
                i_next = i_reg + 1'b1;
                t_next = t_reg + step_reg;
            end
            if (cw.done)
                busy_next = 1'b0;
            if (cw.emit)
            begin
                vtx_valid_next           = 1'b1;
                vtx_beat_next.vert_x     = (cw.emit_src == VS_END) ? req_reg.end_x : cur_x;
                vtx_beat_next.vert_y     = (cw.emit_src == VS_END) ? req_reg.end_y : cur_y;
                vtx_beat_next.vert_color = req_reg.color;
                vtx_beat_next.last       = cw.emit_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= ST_BRANCH;
            i_reg         <= '0;
            t_reg         <= '0;
            vtx_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            t_reg         <= t_next;
            vtx_valid_reg <= vtx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req;
            n_reg    <= N_W'(n_clamp);
            step_reg <= STEP_LUT[n_clamp];
        end
        vtx_beat_reg <= vtx_beat_next;
    end

    assign vtx_valid = vtx_valid_reg;
    assign vtx       = vtx_beat_reg;

    // ---- datapath ---------------------------------------------------------

    always_comb
    begin
        px[0] = req_reg.start_x;
        px[1] = req_reg.ctrl1_x;
        px[2] = req_reg.ctrl2_x;
        px[3] = req_reg.end_x;
        py[0] = req_reg.start_y;
        py[1] = req_reg.ctrl1_y;
        py[2] = req_reg.ctrl2_y;
        py[3] = req_reg.end_y;
    end

    bcf_datapath u_datapath (
        .clk   (clk),
        .ctrl  (dp_ctrl),
        .t     (t_reg),
        .px    (px),
        .py    (py),
        .cur_x (cur_x),
        .cur_y (cur_y)
    );

    // ---- assertions -------------------------------------------------------

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (n_reg != '0) && (n_reg <= N_W'(MAX_SEGMENTS)) && (i_reg <= n_reg))
        else $error("segment count or point index out of range");

    a_idle_at_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> pc_reg == ST_BRANCH)
        else $error("sequencer idle away from entry step");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cw.emit && vtx_valid_reg && !vtx_ready
        |=> pc_reg == $past(pc_reg) && vtx_valid_reg)
        else $error("emit step advanced while output slot full");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        go && cw.emit && cw.emit_last |-> i_reg == n_reg)
        else $error("final vertex issued before all points");

    a_inner_before_end: assert property (@(posedge clk) disable iff (!rst_n)
        go && cw.emit && !cw.emit_last |-> i_reg < n_reg)
        else $error("curve point issued past the segment count");

endmodule

FILE: bench/bezier_curve_flattener_tb.sv
// ----------------------------------------------------------------------------
// bezier_curve_flattener_tb
// Self-checking bench for the curve flattener. A directed table covers
// both curve orders, coordinate extremes, zero and oversized segment counts
// and an ignored second control point. A random run of mostly short curves
// follows. Typed rows are checked against their table vertices, the rest
// against a fixed-point Bernstein evaluator in the bench. Both sides idle at
// random, and the vertex side holds off once, long enough to back up requests.
// ----------------------------------------------------------------------------
module bezier_curve_flattener_tb;
    import bcf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SEG_CAP      = 32;
    localparam int     RANDOM_CURVES = 350;
    localparam int     HOLD_CYCLES  = 4000;
    localparam int     DRAIN_CYCLES = 1000;
    localparam longint CYCLE_LIMIT  = 2_000_000;
    localparam longint COORD_MAX    = 64'sh7FFF_FFFF;
    localparam longint COORD_MIN    = -64'sh8000_0000;

    typedef struct {
        req_beat_t curve;
        bit        typed;
        vtx_beat_t first_vtx;
        vtx_beat_t second_vtx;
    } curve_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_beat_t req;
    logic      vtx_valid;
    logic      vtx_ready;
    vtx_beat_t vtx;

    vtx_beat_t  vertex_q [$];
    curve_row_t curve_table [$];
    int         mismatch_count = 0;
    int         vertices_seen  = 0;
    longint     cycle_count    = 0;

    bezier_curve_flattener dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bezier_curve_flattener_tb NOT OK");
            $finish;
        end
    end

    function automatic void add_row(curve_row_t r);
        curve_table.insert(curve_table.size(), r);
    endfunction

    function automatic void queue_vertex(vtx_beat_t v);
        vertex_q.insert(vertex_q.size(), v);
    endfunction

    function automatic req_beat_t mk_req(logic mode, coord_t sx, coord_t sy,
                                         coord_t c1x, coord_t c1y, coord_t c2x,
                                         coord_t c2y, coord_t ex, coord_t ey,
                                         logic [SEG_W-1:0] segs,
                                         logic [COLOR_W-1:0] col);
        req_beat_t r;
        r.mode     = mode;
        r.start_x  = sx;
        r.start_y  = sy;
        r.ctrl1_x  = c1x;
        r.ctrl1_y  = c1y;
        r.ctrl2_x  = c2x;
        r.ctrl2_y  = c2y;
        r.end_x    = ex;
        r.end_y    = ey;
        r.segments = segs;
        r.color    = col;
        return r;
    endfunction

    function automatic vtx_beat_t mk_vtx(coord_t x, coord_t y,
                                         logic [COLOR_W-1:0] col, logic lst);
        vtx_beat_t v;
        v.vert_x     = x;
        v.vert_y     = y;
        v.vert_color = col;
        v.last       = lst;
        return v;
    endfunction

    // floor(w * p / 2^16), arithmetic shift rounds toward minus infinity
    function automatic longint weighted_term(longint w, longint p);
        return (w * p) >>> T_FRAC;
    endfunction

    function automatic coord_t curve_point(bit cubic, longint t, longint p0,
                                           longint p1, longint p2, longint p3);
        longint u;
        longint u2;
        longint t2;
        longint s;
        u = 65536 - t;
        if (!cubic)
        begin
            s = weighted_term((u * u) >>> T_FRAC, p0)
              + weighted_term((2 * u * t) >>> T_FRAC, p1)
              + weighted_term((t * t) >>> T_FRAC, p3);
        end
        else
        begin
            u2 = (u * u) >>> T_FRAC;
            t2 = (t * t) >>> T_FRAC;
            s = weighted_term((u2 * u) >>> T_FRAC, p0)
              + weighted_term((3 * u2 * t) >>> T_FRAC, p1)
              + weighted_term((3 * u * t2) >>> T_FRAC, p2)
              + weighted_term((t2 * t) >>> T_FRAC, p3);
        end
        if (s > COORD_MAX)
            s = COORD_MAX;
        if (s < COORD_MIN)
            s = COORD_MIN;
        return coord_t'(s);
    endfunction

    function automatic void queue_curve_vertices(req_beat_t r);
        coord_t    px [0:SEG_CAP];
        coord_t    py [0:SEG_CAP];
        longint    n;
        longint    stride;
        vtx_beat_t v;
        n = longint'(r.segments);
        if (n == 0)
            n = 1;
        if (n > longint'(SEG_CAP))
            n = longint'(SEG_CAP);
        stride = 65536 / n;
        for (longint i = 0; i < n; i++)
        begin
            px[i] = curve_point(r.mode, i * stride, longint'(r.start_x),
                                longint'(r.ctrl1_x), longint'(r.ctrl2_x),
                                longint'(r.end_x));
            py[i] = curve_point(r.mode, i * stride, longint'(r.start_y),
                                longint'(r.ctrl1_y), longint'(r.ctrl2_y),
                                longint'(r.end_y));
        end
        // the closing point is the end point itself
        px[n] = r.end_x;
        py[n] = r.end_y;
        for (longint i = 0; i < n; i++)
        begin
            for (longint k = 0; k < 2; k++)
            begin
                v = mk_vtx(px[i + k], py[i + k], r.color,
                           (i == n - 1) && (k == 1));
                queue_vertex(v);
            end
        end
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0:       return coord_t'(COORD_MAX);
            1:       return coord_t'(COORD_MIN);
            2:       return coord_t'($urandom_range(0, 512)) - coord_t'(256);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_curve(curve_row_t row, int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= row.curve;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        if (row.typed)
        begin
            queue_vertex(row.first_vtx);
            queue_vertex(row.second_vtx);
        end
        else
        begin
            queue_curve_vertices(row.curve);
        end
    endtask

    // request side
    initial
    begin
        curve_row_t row;
        bit         calm;
        int         gap;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        calm      = 1'b0;

        // single-segment curves reduce to start then end
        row = '{mk_req(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 6'd1, 32'h0000_0000), 1'b1,
                mk_vtx(0, 0, 32'h0000_0000, 1'b0), mk_vtx(0, 0, 32'h0000_0000, 1'b1)};
        add_row(row);
        row = '{mk_req(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0,
                       32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 6'd1,
                       32'hFFFF_FFFF), 1'b1,
                mk_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0),
                mk_vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1)};
        add_row(row);
        row = '{mk_req(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 6'd1, 32'hA5A5_5A5A), 1'b1,
                mk_vtx(32'h8000_0000, 32'h8000_0000, 32'hA5A5_5A5A, 1'b0),
                mk_vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hA5A5_5A5A, 1'b1)};
        add_row(row);
        // zero segments reads as one
        row = '{mk_req(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h5, 32'h6, 32'h7,
                       32'h8, 32'h0003_8000, 32'hFFFF_FFFF, 6'd0, 32'h1122_3344),
                1'b1,
                mk_vtx(32'h0001_0000, 32'hFFFF_0000, 32'h1122_3344, 1'b0),
                mk_vtx(32'h0003_8000, 32'hFFFF_FFFF, 32'h1122_3344, 1'b1)};
        add_row(row);
        row = '{mk_req(1'b1, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h1, 32'h2, 32'h3,
                       32'h4, 32'hCAFE_0000, 32'h0000_CAFE, 6'd0, 32'h8000_0001),
                1'b1,
                mk_vtx(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h8000_0001, 1'b0),
                mk_vtx(32'hCAFE_0000, 32'h0000_CAFE, 32'h8000_0001, 1'b1)};
        add_row(row);

        // the rest go through the evaluator
        row.typed = 1'b0;
        row.curve = mk_req(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd32, 32'hFFFF_FFFF);
        add_row(row);
        row.curve = mk_req(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 6'd32, 32'h0000_0000);
        add_row(row);
        // oversized counts clamp to the maximum
        row.curve = mk_req(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000,
                           32'h7FFF_FFFF, 6'd63, 32'h0F0F_0F0F);
        add_row(row);
        row.curve = mk_req(1'b1, 32'h0010_0000, 32'hFFF0_0000, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'hFFF0_0000, 32'h0010_0000, 6'd33, 32'hF0F0_F0F0);
        add_row(row);
        // quadratic must ignore the second control point
        row.curve = mk_req(1'b0, 32'h0, 32'h0, 32'h0004_0000, 32'h0004_0000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h0008_0000, 32'h0,
                           6'd2, 32'h1357_9BDF);
        add_row(row);
        row.curve = mk_req(1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 6'd3,
                           32'h2468_ACE0);
        add_row(row);
        // negative inputs exercise rounding toward minus infinity
        row.curve = mk_req(1'b0, -1, -1, -1, -1, -1, -1, -1, -1, 6'd4, 32'h0000_00FF);
        add_row(row);
        row.curve = mk_req(1'b1, -1, -3, -5, -7, -9, -11, -13, -15, 6'd7,
                           32'hFF00_0000);
        add_row(row);
        row.curve = mk_req(1'b0, 1, 1, 1, 1, 1, 1, 1, 1, 6'd5, 32'h00FF_0000);
        add_row(row);
        row.curve = mk_req(1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_8000,
                           32'hFFFD_8000, 32'h0000_8000, 32'hFFFF_8000,
                           32'h0001_0000, 32'hFFFF_0000, 6'd31, 32'h0000_FF00);
        add_row(row);
        row.curve = mk_req(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'hAAAA_AAAA, 6'd16, 32'h5555_AAAA);
        add_row(row);
        row.curve = mk_req(1'b1, 32'h0100_0000, 32'h0100_0000, 32'h0200_0000,
                           32'hFE00_0000, 32'hFE00_0000, 32'h0200_0000,
                           32'h0100_0000, 32'h0100_0000, 6'd2, 32'hAAAA_5555);
        add_row(row);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (curve_table[i])
            send_curve(curve_table[i], $urandom_range(0, 14));

        for (int i = 0; i < RANDOM_CURVES; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
            gap = calm ? 0 : $urandom_range(0, 14);
            row.typed = 1'b0;
            // keep most curves short, a few long or out of range
            row.curve = mk_req(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord(),
                               SEG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                                  : $urandom_range(1, 8)),
                               $urandom);
            send_curve(row, gap);
        end
        req_valid <= 1'b0;

        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (vertex_q.size() != 0)
        begin
            $error("%0d vertex beats never arrived", vertex_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("bezier_curve_flattener_tb OK");
        else
            $display("bezier_curve_flattener_tb NOT OK");
        $finish;
    end

    // vertex side
    initial
    begin
        vtx_beat_t want;
        bit        calm;
        bit        held;
        int        gap;
        vtx_ready = 1'b0;
        calm      = 1'b0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
            gap = calm ? 0 : $urandom_range(0, 14);
            // hold off once so the request side backs up
            if (!held && vertices_seen == 150)
            begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                vtx_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            vtx_ready <= 1'b1;
            do @(posedge clk); while (!vtx_valid);
            vertices_seen++;
            if (vertex_q.size() == 0)
            begin
                $error("vertex beat with nothing expected: x %h y %h", vtx.vert_x,
                       vtx.vert_y);
                mismatch_count++;
            end
            else
            begin
                want = vertex_q.pop_front();
                if (vtx.vert_x !== want.vert_x)
                begin
                    $error("vert_x expected %h got %h", want.vert_x, vtx.vert_x);
                    mismatch_count++;
                end
                if (vtx.vert_y !== want.vert_y)
                begin
                    $error("vert_y expected %h got %h", want.vert_y, vtx.vert_y);
                    mismatch_count++;
                end
                if (vtx.vert_color !== want.vert_color)
                begin
                    $error("vert_color expected %h got %h", want.vert_color,
                           vtx.vert_color);
                    mismatch_count++;
                end
                if (vtx.last !== want.last)
                begin
                    $error("last expected %b got %b", want.last, vtx.last);
                    mismatch_count++;
                end
            end
        end
    end

endmodule

FILE: sim.f
src/bcf_pkg.sv
src/bcf_datapath.sv
src/bezier_curve_flattener.sv
bench/bezier_curve_flattener_tb.sv
